// ===== hw/rtl/owsr_pkg.sv =====
// Shared types and constants for the 1-Wire READ ROM slave.
// Used by owsr_cfg_regs, owsr_proto and onewire_slave_read_rom_unit; depends on nothing.
package owsr_pkg;

  // ROM geometry
  localparam int unsigned RomBitsDef = 64;
  localparam int unsigned RomCodeW   = 64;
  localparam int unsigned RomSelW    = $clog2(RomCodeW);

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // 1-Wire command codes
  localparam logic [7:0] CmdNone    = 8'h00;
  localparam logic [7:0] CmdReadRom = 8'h33;

  // Register defaults
  localparam logic [63:0] RomCodeDef     = 64'hC400_0009_7D79_0401;
  localparam logic [11:0] ResetMinUsDef  = 12'd256;
  localparam logic [7:0]  ZeroMinUsDef   = 8'd16;
  localparam logic [7:0]  PresenceUsDef  = 8'd120;
  localparam logic [5:0]  DataZeroUsDef  = 6'd15;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROM_CODE     = 3'd0,
    CFG_RESET_MIN_US = 3'd1,
    CFG_ZERO_MIN_US  = 3'd2,
    CFG_PRESENCE_US  = 3'd3,
    CFG_DATA_ZERO_US = 3'd4
  } cfg_idx_e;

  // Kind of reply requested on the bus
  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_PRESENCE = 2'd1,
    KIND_ZERO_BIT = 2'd2
  } reply_kind_e;

  // Bus event kind
  typedef enum logic {
    EV_SLOT_START = 1'b0,
    EV_SLOT_END   = 1'b1
  } func_e;

  typedef struct packed {
    logic [63:0] rom_code;
    logic [11:0] reset_min_us;
    logic [7:0]  zero_min_us;
    logic [7:0]  presence_us;
    logic [5:0]  data_zero_us;
  } cfg_t;

  typedef struct packed {
    logic        func;
    logic [11:0] low_time_us;
  } in_word_t;

  typedef struct packed {
    logic        drive_low;
    logic [7:0]  drive_time_us;
    reply_kind_e reply_kind;
    logic        rom_sending;
    logic        command_done;
  } out_word_t;

endpackage

// ===== hw/rtl/owsr_cfg_regs.sv =====
// Configuration register file for the 1-Wire READ ROM slave.
// Depends on owsr_pkg.
module owsr_cfg_regs import owsr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  // Write decode; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rom_code     <= RomCodeDef;
      cfg_q.reset_min_us <= ResetMinUsDef;
      cfg_q.zero_min_us  <= ZeroMinUsDef;
      cfg_q.presence_us  <= PresenceUsDef;
      cfg_q.data_zero_us <= DataZeroUsDef;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROM_CODE:     cfg_q.rom_code     <= cfg_wdata_i[63:0];
        CFG_RESET_MIN_US: cfg_q.reset_min_us <= cfg_wdata_i[11:0];
        CFG_ZERO_MIN_US:  cfg_q.zero_min_us  <= cfg_wdata_i[7:0];
        CFG_PRESENCE_US:  cfg_q.presence_us  <= cfg_wdata_i[7:0];
        CFG_DATA_ZERO_US: cfg_q.data_zero_us <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/owsr_proto.sv =====
// Protocol state and per-event step of the 1-Wire READ ROM slave.
// Depends on owsr_pkg.
module owsr_proto import owsr_pkg::*; #(
  parameter int unsigned RomBits = RomBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_word_t  word_i,
  input  cfg_t      cfg_i,
  output out_word_t result_o
);

  localparam int unsigned IdxW = $clog2(RomBits);

  logic [7:0]      shift_q, shift_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [7:0]      latched_q, latched_d;
  logic [IdxW-1:0] idx_q, idx_d;

  logic            is_reset;
  logic            rom_bit;
  logic [IdxW:0]   idx_inc;
  logic            last_bit;
  logic [7:0]      shift_new;

  // Event classification
  assign is_reset  = (word_i.func == EV_SLOT_END) && (word_i.low_time_us >= cfg_i.reset_min_us);
  assign rom_bit   = cfg_i.rom_code[RomSelW'(idx_q)];
  assign idx_inc   = {1'b0, idx_q} + 1'b1;
  assign last_bit  = (idx_inc == (IdxW+1)'(RomBits));

  always_comb begin
    shift_new = shift_q;
    shift_new[cnt_q] = (word_i.low_time_us < {4'd0, cfg_i.zero_min_us});
  end

  // Next state and result word
  always_comb begin
    shift_d   = shift_q;
    cnt_d     = cnt_q;
    latched_d = latched_q;
    idx_d     = idx_q;
    result_o  = '0;
    result_o.reply_kind = KIND_NONE;

    if (word_i.func == EV_SLOT_END) begin
      if (is_reset) begin
        result_o.drive_low     = 1'b1;
        result_o.drive_time_us = cfg_i.presence_us;
        result_o.reply_kind    = KIND_PRESENCE;
        shift_d   = '0;
        cnt_d     = '0;
        latched_d = CmdNone;
      end else if (latched_q == CmdNone) begin
        // receive one command bit, LSB first; latch on the eighth
        if (cnt_q == 3'd7) begin
          latched_d = shift_new;
          idx_d     = '0;
          shift_d   = '0;
          cnt_d     = '0;
        end else begin
          shift_d = shift_new;
          cnt_d   = cnt_q + 3'd1;
        end
      end
    end else if (latched_q == CmdReadRom) begin
      // send next ROM bit; a zero is a short pull-low
      if (!rom_bit) begin
        result_o.drive_low     = 1'b1;
        result_o.drive_time_us = {2'b00, cfg_i.data_zero_us};
        result_o.reply_kind    = KIND_ZERO_BIT;
      end
      if (last_bit) begin
        result_o.command_done = 1'b1;
        idx_d     = '0;
        shift_d   = '0;
        cnt_d     = '0;
        latched_d = CmdNone;
      end else begin
        idx_d = idx_inc[IdxW-1:0];
      end
    end

    result_o.rom_sending = (latched_d == CmdReadRom);
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q   <= '0;
      cnt_q     <= '0;
      latched_q <= CmdNone;
      idx_q     <= '0;
    end else if (fire_i) begin
      shift_q   <= shift_d;
      cnt_q     <= cnt_d;
      latched_q <= latched_d;
      idx_q     <= idx_d;
    end
  end

`ifndef SYNTHESIS
  // A presence reply always leaves the receiver cleared
  a_presence_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && result_o.reply_kind == KIND_PRESENCE |=> latched_q == CmdNone && cnt_q == 3'd0)
    else $error("receiver not cleared after bus reset");

  // End of transfer restarts the ROM index and drops the command
  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && result_o.command_done |=> idx_q == '0 && latched_q == CmdNone)
    else $error("state not cleared after last ROM bit");
`endif

endmodule

// ===== hw/rtl/onewire_slave_read_rom_unit.sv =====
// Channel    | Direction | Handshake                 | Word
// -----------+-----------+---------------------------+--------------------------
// input      | in        | in_valid_i / in_stall_o   | in_word_i  (in_word_t)
// output     | out       | out_valid_o / out_stall_i | out_word_o (out_word_t)
// config     | in        | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// One word is accepted per cycle while in_stall_o is low; its result word passes the input
// register, then the result register; one result per cycle drains while not stalled.
// Reset clears both valid flags and the protocol state; registers take defaults.
// out_stall_i holds the result register and, only when the input register is
// also full, raises in_stall_o in the same cycle.
// Top level of the 1-Wire READ ROM slave. Depends on owsr_pkg, owsr_cfg_regs, owsr_proto.
module onewire_slave_read_rom_unit import owsr_pkg::*; #(
  parameter int unsigned RomBits = RomBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_word_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t      cfg;
  logic      in_valid_q;
  in_word_t  in_word_q;
  logic      out_valid_q;
  out_word_t out_word_q;
  out_word_t result;
  logic      out_adv;
  logic      fire;

  owsr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Flow control
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_adv;
  assign in_stall_o = in_valid_q && !out_adv;

  owsr_proto #(.RomBits(RomBits)) u_proto (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .word_i   (in_word_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (out_adv)     out_valid_q <= in_valid_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) in_word_q <= in_word_i;
    if (fire) out_word_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTHESIS
  // A held input word is not lost while the result side is blocked
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> in_valid_q)
    else $error("stalled input word dropped");

  // Input stall only comes from a full, stalled result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i && in_valid_q)
    else $error("input stalled without cause");
`endif

endmodule

// ===== test/onewire_slave_read_rom_unit_tb.sv =====
// Self-checking testbench for onewire_slave_read_rom_unit: directed bus events, then random
// reset/command/ROM-read sequences under several register settings, with random idling on both sides.
// Depends on owsr_pkg and the RTL of onewire_slave_read_rom_unit only.
`timescale 1ns / 1ps

module onewire_slave_read_rom_unit_tb;
  import owsr_pkg::*;

  // Stimulus script rows: one bus event, repeated, with an optional hand-written reply
  typedef struct {
    func_e       func;
    logic [11:0] low;
    int unsigned reps;
    bit          typed;
    out_word_t   want;
  } script_row_t;

  localparam out_word_t Quiet = '0;
  localparam out_word_t Presence = '{drive_low: 1'b1, drive_time_us: PresenceUsDef,
                                     reply_kind: KIND_PRESENCE, rom_sending: 1'b0,
                                     command_done: 1'b0};

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_word_t            in_word_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_word_t           out_word_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = CFG_ROM_CODE;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  // Hand-written reply travels with the word it belongs to
  bit        tag_typed = 1'b0;
  out_word_t tag_word  = '0;

  // Slave model: register copies and protocol state
  logic [63:0] rom_word  = RomCodeDef;
  logic [11:0] reset_min = ResetMinUsDef;
  logic [7:0]  zero_min  = ZeroMinUsDef;
  logic [7:0]  presence  = PresenceUsDef;
  logic [5:0]  data_zero = DataZeroUsDef;
  logic [7:0]  cmd_shift   = '0;
  logic [3:0]  cmd_count   = '0;
  logic [7:0]  cmd_latched = CmdNone;
  logic [6:0]  rom_idx     = '0;

  out_word_t   replies_due[$];
  int unsigned n_sent    = 0;
  int unsigned n_results = 0;
  int unsigned n_bad     = 0;
  bit          calm      = 1'b0;

  script_row_t script [25] = '{
    '{EV_SLOT_START, 12'd0,    1,  1'b1, Quiet},     // start with no command: nothing
    '{EV_SLOT_END,   12'd4095, 1,  1'b1, Presence},  // longest low: reset
    '{EV_SLOT_END,   12'd256,  1,  1'b1, Presence},  // low exactly at reset threshold
    '{EV_SLOT_END,   12'd255,  7,  1'b1, Quiet},     // zero bits just under reset
    '{EV_SLOT_END,   12'd16,   1,  1'b1, Quiet},     // eighth zero: command byte zero
    '{EV_SLOT_END,   12'd0,    1,  1'b0, Quiet},     // READ ROM, LSB first: 1
    '{EV_SLOT_END,   12'd15,   1,  1'b0, Quiet},     // 1 at threshold - 1
    '{EV_SLOT_END,   12'd16,   2,  1'b0, Quiet},     // 0, 0
    '{EV_SLOT_END,   12'd1,    2,  1'b0, Quiet},     // 1, 1
    '{EV_SLOT_END,   12'd200,  1,  1'b0, Quiet},     // 0
    '{EV_SLOT_END,   12'd255,  1,  1'b0, Quiet},     // 0, command latched
    '{EV_SLOT_START, 12'hfff,  64, 1'b0, Quiet},     // full transfer, low time ignored
    '{EV_SLOT_START, 12'd0,    1,  1'b1, Quiet},     // transfer over
    '{EV_SLOT_END,   12'd3,    8,  1'b1, Quiet},     // other command 0xff
    '{EV_SLOT_START, 12'd0,    1,  1'b1, Quiet},     // ignored while other command held
    '{EV_SLOT_END,   12'd100,  2,  1'b1, Quiet},
    '{EV_SLOT_END,   12'd300,  1,  1'b1, Presence},  // reset frees the receiver
    '{EV_SLOT_END,   12'd5,    2,  1'b0, Quiet},     // READ ROM again
    '{EV_SLOT_END,   12'd90,   2,  1'b0, Quiet},
    '{EV_SLOT_END,   12'd7,    2,  1'b0, Quiet},
    '{EV_SLOT_END,   12'd250,  2,  1'b0, Quiet},
    '{EV_SLOT_START, 12'd0,    5,  1'b0, Quiet},
    '{EV_SLOT_END,   12'd9,    1,  1'b0, Quiet},     // slot end mid-transfer: nothing
    '{EV_SLOT_END,   12'd4095, 1,  1'b1, Presence},  // reset during transfer
    '{EV_SLOT_START, 12'd0,    1,  1'b1, Quiet}
  };

  onewire_slave_read_rom_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

  function automatic void clear_receiver();
    cmd_shift   = '0;
    cmd_count   = '0;
    cmd_latched = CmdNone;
  endfunction

  // Slave reply to one bus event; advances the model state
  function automatic out_word_t slave_reply(input in_word_t w);
    out_word_t r;
    r = '0;
    if (w.func == EV_SLOT_END) begin
      if (w.low_time_us >= reset_min) begin
        r.drive_low     = 1'b1;
        r.drive_time_us = presence;
        r.reply_kind    = KIND_PRESENCE;
        clear_receiver();
      end else if (cmd_latched == CmdNone) begin
        // short low is a 1, long low a 0, LSB first
        if (w.low_time_us < {4'b0, zero_min} && cmd_count < 8)
          cmd_shift[cmd_count[2:0]] = 1'b1;
        cmd_count = cmd_count + 4'd1;
        if (cmd_count >= 8) begin
          cmd_latched = cmd_shift;
          rom_idx     = '0;
          cmd_shift   = '0;
          cmd_count   = '0;
        end
      end
    end else if (cmd_latched == CmdReadRom) begin
      // zero ROM bits are sent as a short pull-low
      if (!rom_word[rom_idx[5:0]]) begin
        r.drive_low     = 1'b1;
        r.drive_time_us = {2'b0, data_zero};
        r.reply_kind    = KIND_ZERO_BIT;
      end
      rom_idx = rom_idx + 7'd1;
      if (rom_idx >= RomBitsDef) begin
        r.command_done = 1'b1;
        rom_idx        = '0;
        clear_receiver();
      end
    end
    r.rom_sending = (cmd_latched == CmdReadRom);
    return r;
  endfunction

  // Low time that encodes one command bit under the current thresholds
  function automatic logic [11:0] bit_low(input bit one);
    int unsigned lo, hi;
    lo = one ? 0 : zero_min;
    hi = one ? zero_min : reset_min;
    if (hi > lo) return 12'($urandom_range(hi - 1, lo));
    return 12'(lo);
  endfunction

  // Expected reply for every accepted word
  always @(posedge clk_i) begin
    out_word_t r;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      r = slave_reply(in_word_i);
      replies_due.push_back(tag_typed ? tag_word : r);
    end
  end

  // Output side stalls at random
  always @(posedge clk_i) out_stall_i <= !calm && ($urandom_range(99) < 32);

  task automatic flag_reply(input string why, input out_word_t want, input out_word_t got);
    n_bad++;
    if (n_bad <= 10) begin
      $write("%0t %s: expected drive=%0d time=%0d kind=%0d sending=%0d done=%0d",
             $time, why, want.drive_low, want.drive_time_us, want.reply_kind,
             want.rom_sending, want.command_done);
      $display(", got drive=%0d time=%0d kind=%0d sending=%0d done=%0d",
               got.drive_low, got.drive_time_us, got.reply_kind, got.rom_sending,
               got.command_done);
    end
  endtask

  // Compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (replies_due.size() == 0) begin
        flag_reply("unexpected word", Quiet, out_word_o);
      end else begin
        want = replies_due.pop_front();
        if (out_word_o.drive_low !== want.drive_low ||
            out_word_o.drive_time_us !== want.drive_time_us ||
            out_word_o.reply_kind !== want.reply_kind ||
            out_word_o.rom_sending !== want.rom_sending ||
            out_word_o.command_done !== want.command_done)
          flag_reply("mismatch", want, out_word_o);
      end
    end
  end

  // Present one word and hold it until accepted; called at a rising edge
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    bit taken;
    while (!calm && $urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    tag_typed  <= typed;
    tag_word   <= want;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    n_sent++;
  endtask

  // Let every pending reply come out
  task automatic drain();
    in_valid_i <= 1'b0;
    while (n_results < n_sent) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(input cfg_idx_e idx, input logic [63:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    case (idx)
      CFG_ROM_CODE:     rom_word  = v;
      CFG_RESET_MIN_US: reset_min = v[11:0];
      CFG_ZERO_MIN_US:  zero_min  = v[7:0];
      CFG_PRESENCE_US:  presence  = v[7:0];
      CFG_DATA_ZERO_US: data_zero = v[5:0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input logic [63:0] rom, input logic [11:0] rmin,
                           input logic [7:0] zmin, input logic [7:0] pres,
                           input logic [5:0] dz);
    drain();
    reg_write(CFG_ROM_CODE, rom);
    reg_write(CFG_RESET_MIN_US, 64'(rmin));
    reg_write(CFG_ZERO_MIN_US, 64'(zmin));
    reg_write(CFG_PRESENCE_US, 64'(pres));
    reg_write(CFG_DATA_ZERO_US, 64'(dz));
    cfg_we_i <= 1'b0;
  endtask

  // Mostly reset / command / ROM-read sequences, some raw noise
  task automatic run_traffic(input int unsigned n_items);
    int unsigned first, slots;
    logic [7:0]  cmd;
    in_word_t    w;
    first = n_sent;
    while (n_sent - first < n_items) begin
      if ($urandom_range(99) < 80) begin
        w.func        = EV_SLOT_END;
        w.low_time_us = 12'($urandom_range(4095, reset_min));
        send_word(w, 1'b0, Quiet);
        cmd = ($urandom_range(99) < 80) ? CmdReadRom : 8'($urandom);
        for (int b = 0; b < 8; b++) begin
          w.low_time_us = bit_low(cmd[b]);
          send_word(w, 1'b0, Quiet);
        end
        if (cmd != CmdReadRom) slots = $urandom_range(4, 0);
        else if ($urandom_range(99) < 75) slots = RomBitsDef;
        else slots = $urandom_range(RomBitsDef - 1, 1);
        for (int s = 0; s < slots; s++) begin
          w.func        = EV_SLOT_START;
          w.low_time_us = 12'($urandom);
          send_word(w, 1'b0, Quiet);
          if ($urandom_range(1)) begin
            w.func        = EV_SLOT_END;
            w.low_time_us = bit_low(1'b1);
            send_word(w, 1'b0, Quiet);
          end
        end
      end else begin
        repeat ($urandom_range(12, 1)) begin
          w.func        = func_e'($urandom_range(1));
          w.low_time_us = 12'($urandom);
          send_word(w, 1'b0, Quiet);
        end
      end
    end
  endtask

  initial begin
    in_word_t w;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed events under reset defaults
    foreach (script[i]) begin
      repeat (script[i].reps) begin
        w.func        = script[i].func;
        w.low_time_us = script[i].low;
        send_word(w, script[i].typed, script[i].want);
      end
    end

    // Defaults again, no idling on either side
    calm = 1'b1;
    run_traffic(200);
    drain();
    calm = 1'b0;

    // Upper extremes
    apply_cfg({$urandom, $urandom}, 12'd4095, 8'd255, 8'd255, 6'd63);
    run_traffic(200);

    // Lower extremes, all-zero ROM
    apply_cfg(64'h0, 12'd2, 8'd1, 8'd1, 6'd1);
    run_traffic(150);

    // All-ones ROM, random thresholds
    apply_cfg('1, 12'($urandom_range(4095, 300)), 8'($urandom_range(255, 1)),
              8'($urandom_range(255, 1)), 6'($urandom_range(63, 1)));
    run_traffic(200);

    // Zero thresholds: every slot end is a reset
    apply_cfg({$urandom, $urandom}, 12'd0, 8'd0, 8'd0, 6'd0);
    run_traffic(100);

    // Zero bit threshold only: every bit reads as 0
    apply_cfg({$urandom, $urandom}, 12'd256, 8'd0, 8'd77, 6'd33);
    run_traffic(100);

    // Random typical setting
    apply_cfg({$urandom, $urandom}, 12'($urandom_range(4095, 256)), 8'($urandom_range(255, 1)),
              8'($urandom_range(255, 1)), 6'($urandom_range(63, 1)));
    run_traffic(300);

    drain();
    if (replies_due.size() != 0) begin
      $display("%0d expected words never arrived", replies_due.size());
      n_bad += replies_due.size();
    end
    if (n_bad == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/owsr_pkg.sv
hw/rtl/owsr_cfg_regs.sv
hw/rtl/owsr_proto.sv
hw/rtl/onewire_slave_read_rom_unit.sv
test/onewire_slave_read_rom_unit_tb.sv
